>>> rtl/wpslm_pkg.sv
`timescale 1ns / 1ps

package wpslm_pkg;

    localparam int P2P_MAX_W = 16;

    localparam logic [1:0] CFG_WINDOW_MS    = 2'd0;
    localparam logic [1:0] CFG_WINDOW_COUNT = 2'd1;
    localparam int         CFG_IDX_W        = 2;
    localparam int         CFG_DATA_W       = 16;

    localparam logic [15:0] RESET_WINDOW_MS    = 16'd50;
    localparam logic [7:0]  RESET_WINDOW_COUNT = 8'd5;

    // 20*log10(2) in Q16.
    localparam logic [18:0] DB_PER_OCTAVE_Q16 = 19'd394566;
    // 16.152 dB in 1/256 dB.
    localparam logic [15:0] LEVEL_OFFSET = 16'd4135;
    localparam logic signed [15:0] LEVEL_FLOOR = 16'sh8000;
    localparam logic signed [15:0] LEVEL_TOP   = 16'sh7FFF;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    typedef struct packed {
        logic                 last;
        logic [P2P_MAX_W-1:0] p2p;
    } t_win;

    // Fractional part of log2(1 + idx/2^bits) in Q16, found by repeated
    // squaring in Q30. Only ever called with constant arguments.
    function automatic logic [15:0] log_frac(input int unsigned idx, input int unsigned bits);
        logic [63:0] x;
        logic [15:0] frac;
        x    = 64'((64'(1) << bits) + 64'(idx)) << (30 - bits);
        frac = '0;
        for (int r = 0; r < 16; r++) begin
            x    = (x * x) >> 30;
            frac = {frac[14:0], 1'b0};
            if (x >= (64'd2 << 30)) begin
                frac[0] = 1'b1;
                x       = x >> 1;
            end
        end
        return frac;
    endfunction

endpackage

>>> rtl/wpslm_front.sv
`timescale 1ns / 1ps

module wpslm_front
    import wpslm_pkg::*;
#(
    parameter int ADC_RANGE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_req_type,
    input  logic [15:0]           i_sample_value,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_win                  o_entry
);

    localparam logic [16:0] ADC_LIMIT = 17'(17'd1 << ADC_RANGE_BITS);

    logic [15:0]               r_window_ms;
    logic [7:0]                r_window_count;
    logic [15:0]               r_tick, n_tick;
    logic [7:0]                r_win_idx, n_win_idx;
    logic [ADC_RANGE_BITS-1:0] r_max, n_max;
    logic [ADC_RANGE_BITS:0]   r_min, n_min;

    logic                      w_accept;
    logic                      w_sample_ok;
    logic [ADC_RANGE_BITS-1:0] w_sample;
    logic [15:0]               w_tick_inc;
    logic [15:0]               w_lim_ms;
    logic [7:0]                w_idx_inc;
    logic [7:0]                w_lim_cnt;
    logic                      w_close;
    logic                      w_last;
    logic [ADC_RANGE_BITS-1:0] w_p2p;

    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;

    always_comb begin
        w_sample_ok = {1'b0, i_sample_value} < ADC_LIMIT;
        w_sample    = i_sample_value[ADC_RANGE_BITS-1:0];
        w_tick_inc  = r_tick + 16'd1;
        w_lim_ms    = (r_window_ms == '0) ? 16'd1 : r_window_ms;
        w_idx_inc   = r_win_idx + 8'd1;
        w_lim_cnt   = (r_window_count == '0) ? 8'd1 : r_window_count;
        w_close     = w_tick_inc >= w_lim_ms;
        w_last      = w_idx_inc >= w_lim_cnt;
        // An empty window leaves min above max; that reads as zero amplitude.
        if (r_min > {1'b0, r_max}) begin
            w_p2p = '0;
        end else begin
            w_p2p = r_max - r_min[ADC_RANGE_BITS-1:0];
        end

        n_tick    = r_tick;
        n_win_idx = r_win_idx;
        n_max     = r_max;
        n_min     = r_min;
        o_push    = 1'b0;
        if (w_accept) begin
            if (!i_req_type) begin
                if (w_sample_ok) begin
                    if (w_sample > r_max) begin
                        n_max = w_sample;
                    end
                    if (w_sample != '0 && {1'b0, w_sample} < r_min) begin
                        n_min = {1'b0, w_sample};
                    end
                end
            end else if (w_close) begin
                o_push    = 1'b1;
                n_tick    = '0;
                n_max     = '0;
                n_min     = ADC_LIMIT[ADC_RANGE_BITS:0];
                n_win_idx = w_last ? 8'd0 : w_idx_inc;
            end else begin
                n_tick = w_tick_inc;
            end
        end

        o_entry.last = w_last;
        o_entry.p2p  = P2P_MAX_W'(w_p2p);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms    <= RESET_WINDOW_MS;
            r_window_count <= RESET_WINDOW_COUNT;
            r_tick         <= '0;
            r_win_idx      <= '0;
            r_max          <= '0;
            r_min          <= ADC_LIMIT[ADC_RANGE_BITS:0];
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WINDOW_MS) begin
                    r_window_ms <= i_cfg_data[15:0];
                end else if (i_cfg_index == CFG_WINDOW_COUNT) begin
                    r_window_count <= i_cfg_data[7:0];
                end
            end
            r_tick    <= n_tick;
            r_win_idx <= n_win_idx;
            r_max     <= n_max;
            r_min     <= n_min;
        end
    end

endmodule

>>> rtl/wpslm_queue.sv
`timescale 1ns / 1ps

module wpslm_queue
    import wpslm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_win i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_win o_data
);

    t_win               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;
    logic               w_pop;

    assign o_full  = r_count == (Q_PTR_W + 1)'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/wpslm_back.sv
`timescale 1ns / 1ps

module wpslm_back
    import wpslm_pkg::*;
#(
    parameter int ADC_RANGE_BITS = 10,
    parameter int LOG_TABLE_BITS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_win               i_q_data,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_level_db,
    output logic               o_silent_window
);

    localparam int TAB_SIZE = 1 << LOG_TABLE_BITS;
    localparam int EW       = $clog2(ADC_RANGE_BITS);
    localparam int L2W      = EW + 16;
    localparam int PW       = L2W + 19;
    localparam int SHW      = ADC_RANGE_BITS + LOG_TABLE_BITS;

    logic [15:0] w_tab [TAB_SIZE];

    for (genvar g = 0; g < TAB_SIZE; g++) begin : g_tab
        assign w_tab[g] = log_frac(g, LOG_TABLE_BITS);
    end

    logic                      w_adv;
    logic [ADC_RANGE_BITS-1:0] w_p2p;
    logic [EW-1:0]             w_e;
    logic [SHW-1:0]            w_sh;
    logic [LOG_TABLE_BITS-1:0] w_idx;
    logic [PW-1:0]             w_rnd;
    logic [23:0]               w_lvw;
    logic signed [15:0]        w_lv;
    logic                      w_lower;

    logic               r_v1, r_v2, r_v3;
    logic               r_last1, r_last2, r_last3;
    logic               r_sil1, r_sil2, r_sil3;
    logic [L2W-1:0]     r_l2;
    logic [PW-1:0]      r_prod;
    logic signed [15:0] r_lv3;
    logic signed [15:0] r_lowest;
    logic               r_lowest_sil;
    logic               r_out_valid;
    logic signed [15:0] r_out_level;
    logic               r_out_sil;

    // The whole pipeline holds while a finished result waits downstream.
    assign w_adv = !r_out_valid || !i_out_stall;
    assign o_pop = i_q_valid && w_adv;

    always_comb begin
        w_p2p = i_q_data.p2p[ADC_RANGE_BITS-1:0];
        w_e   = '0;
        for (int i = 0; i < ADC_RANGE_BITS; i++) begin
            if (w_p2p[i]) begin
                w_e = EW'(i);
            end
        end
        // The bits just below the leading one, zero-filled from below.
        w_sh  = {w_p2p, {LOG_TABLE_BITS{1'b0}}} >> w_e;
        w_idx = w_sh[LOG_TABLE_BITS-1:0];

        w_rnd = r_prod + (PW'(1) << 23);
        w_lvw = 24'(w_rnd >> 24) + 24'(LEVEL_OFFSET);
        if (r_sil2) begin
            w_lv = LEVEL_FLOOR;
        end else if (w_lvw > 24'(LEVEL_TOP)) begin
            w_lv = LEVEL_TOP;
        end else begin
            w_lv = w_lvw[15:0];
        end

        w_lower = r_lv3 < r_lowest;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_last1 <= i_q_data.last;
            r_sil1  <= w_p2p == '0;
            r_l2    <= {w_e, w_tab[w_idx]};
            r_last2 <= r_last1;
            r_sil2  <= r_sil1;
            r_prod  <= PW'(r_l2) * PW'(DB_PER_OCTAVE_Q16);
            r_last3 <= r_last2;
            r_sil3  <= r_sil2;
            r_lv3   <= w_lv;
            if (r_v3 && r_last3) begin
                r_out_level <= w_lower ? r_lv3 : r_lowest;
                r_out_sil   <= w_lower ? r_sil3 : r_lowest_sil;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_out_valid  <= 1'b0;
            r_lowest     <= LEVEL_TOP;
            r_lowest_sil <= 1'b0;
        end else if (w_adv) begin
            r_v1        <= o_pop;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_out_valid <= r_v3 && r_last3;
            if (r_v3) begin
                if (r_last3) begin
                    r_lowest     <= LEVEL_TOP;
                    r_lowest_sil <= 1'b0;
                end else if (w_lower) begin
                    r_lowest     <= r_lv3;
                    r_lowest_sil <= r_sil3;
                end
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_level_db      = r_out_level;
    assign o_silent_window = r_out_sil;

endmodule

>>> rtl/windowed_peak_sound_level_meter.sv
`timescale 1ns / 1ps
// Channel   Ports                                          Direction
// input     i_in_valid, o_in_stall, i_req_type,            in
//           i_sample_value
// output    o_out_valid, i_out_stall, o_level_db,          out
//           o_silent_window
// config    i_cfg_we, i_cfg_index, i_cfg_data              in, write only
//
// One request is taken per cycle while the queue is not full. A tick that
// closes a window enters a four-entry queue; the log pipeline behind it
// (leading-one and table, multiply, round and clamp, lowest-level update)
// turns it into the result. Reset is synchronous and active low and needs
// no clearing pass. The input stalls only when the queue is full; the back
// end holds while the output register is stalled.

module windowed_peak_sound_level_meter
    import wpslm_pkg::*;
#(
    parameter int ADC_RANGE_BITS = 10,
    parameter int LOG_TABLE_BITS = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic [15:0]           i_sample_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [15:0]    o_level_db,
    output logic                  o_silent_window,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic q_full;
    logic q_push;
    t_win q_in;
    logic q_pop;
    logic q_valid;
    t_win q_out;

    wpslm_front #(
        .ADC_RANGE_BITS(ADC_RANGE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_req_type    (i_req_type),
        .i_sample_value(i_sample_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_entry       (q_in)
    );

    wpslm_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_out)
    );

    wpslm_back #(
        .ADC_RANGE_BITS(ADC_RANGE_BITS),
        .LOG_TABLE_BITS(LOG_TABLE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_data       (q_out),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_level_db     (o_level_db),
        .o_silent_window(o_silent_window)
    );

endmodule

>>> rtl/wpslm_checker.sv
`timescale 1ns / 1ps

module wpslm_checker
    import wpslm_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [15:0] o_level_db,
    input logic               o_silent_window
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_level_db)
            && $stable(o_silent_window))
        else $error("stalled result changed or vanished");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_silent_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_silent_window |-> o_level_db == LEVEL_FLOOR)
        else $error("silent window without floor level");

    // A nonzero amplitude never reads below the fixed offset.
    a_level_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_silent_window |-> o_level_db >= $signed({1'b0, LEVEL_OFFSET}))
        else $error("level below offset for nonzero amplitude");

    // A single request cannot produce a result straight after reset is released.
    a_no_early: assert property (@(posedge i_clk)
        !i_rst_n ##1 i_rst_n |=> !o_out_valid)
        else $error("result appeared too early after reset");

endmodule

bind windowed_peak_sound_level_meter wpslm_checker u_wpslm_checker (.*);
